// File: rtl/rhba_pkg.sv
// shared types and constants for the refcounted handle bump allocator
// no dependencies; imported by every rtl module of the block
`default_nettype none

package rhba_pkg;

  localparam int HANDLE_COUNT_DEF = 256;
  localparam int POOL_BYTES       = 65536;
  localparam int TBL_MAX          = 256;

  localparam int HANDLE_W = 8;
  localparam int LEN_W    = 17;
  localparam int REFS_W   = 16;
  localparam int CODE_W   = 3;
  localparam int ALU_W    = LEN_W + 1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // largest byte count the pool can ever hold, clipped to the length field
  localparam logic [LEN_W-1:0] POOL_LIM =
    (POOL_BYTES > 131071) ? {LEN_W{1'b1}} : LEN_W'(POOL_BYTES);
  localparam logic [LEN_W-1:0] POOL_SIZE_RST = 17'h10000;

  localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

  // command codes
  localparam logic [CODE_W-1:0] CMD_CREATE   = 3'd0;
  localparam logic [CODE_W-1:0] CMD_WR_CHECK = 3'd1;
  localparam logic [CODE_W-1:0] CMD_RD_CHECK = 3'd2;
  localparam logic [CODE_W-1:0] CMD_ADD_REF  = 3'd3;
  localparam logic [CODE_W-1:0] CMD_DROP_REF = 3'd4;

  // status codes
  localparam logic [CODE_W-1:0] STS_OK        = 3'd0;
  localparam logic [CODE_W-1:0] STS_POOL_FULL = 3'd1;
  localparam logic [CODE_W-1:0] STS_UNKNOWN   = 3'd2;
  localparam logic [CODE_W-1:0] STS_MISMATCH  = 3'd3;
  localparam logic [CODE_W-1:0] STS_NO_HANDLE = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [REFS_W-1:0] refs;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  offset;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic                live;
    logic [HANDLE_W-1:0] addr;
    entry_t              data;
  } tbl_wr_t;

endpackage

`default_nettype wire

// File: rtl/rhba_alu.sv
// shared add/subtract unit with zero and less-or-equal flags
// depends on rhba_pkg
`default_nettype none

module rhba_alu (
  input  rhba_pkg::alu_req_t          req,
  output logic [rhba_pkg::ALU_W-1:0]  res,
  output logic                        zero,
  output logic                        le
);
  import rhba_pkg::*;

  always_comb begin
    case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_SUB: res = req.a - req.b;
      default: res = req.a + req.b;
    endcase
  end

  assign zero = (res == '0);
  assign le   = (res <= req.c);

endmodule

`default_nettype wire

// File: rtl/rhba_table.sv
// handle table: entry memory with registered read plus live bits in flops
// depends on rhba_pkg
`default_nettype none

module rhba_table #(
  parameter int DEPTH = rhba_pkg::TBL_MAX
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  rhba_pkg::tbl_wr_t                wr,
  input  wire                              rd_en,
  input  wire [rhba_pkg::HANDLE_W-1:0]     rd_addr,
  output rhba_pkg::entry_t                 rd_data,
  output logic                             rd_live
);
  import rhba_pkg::*;

  localparam int AW = $clog2(DEPTH);

  entry_t             mem_r [DEPTH];
  logic [DEPTH-1:0]   live_r;
  entry_t             rd_data_r;
  logic               rd_live_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      rd_live_r <= 1'b0;
    end else begin
      if (wr.en) begin
        live_r[wr.addr[AW-1:0]] <= wr.live;
      end
      if (rd_en) begin
        rd_live_r <= live_r[rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_live = rd_live_r;

endmodule

`default_nettype wire

// File: rtl/refcounted_handle_bump_allocator_core.sv
// top level of the refcounted handle bump allocator: sequencer, bump state, result register
// depends on rhba_pkg, rhba_alu and rhba_table
`default_nettype none

// Handle table over a byte pool. create hands out handles 1, 2, 3, ... and
// carves the requested length at the bump offset; space and handles are never
// reused. write/read checks confirm the handle is live and the length matches,
// then report the region for an external data mover. add_ref raises the count
// (saturating), drop_ref lowers it and frees the entry at zero, flagging
// released. Each item goes through the registered table read started when
// the item is accepted, then through the shared adder/comparator that
// resolves the command and writes the table back. in_tready is high only while
// the sequencer is idle; a finished result sits in the output register, so the
// next item can be taken while it waits, and the sequencer holds in its
// execute step only while that register is still full. No clearing pass is
// needed: the live bits are cleared by reset at once. pool_size is written
// through cfg_* (always ready) and should only change while the block is idle.

module refcounted_handle_bump_allocator_core #(
  parameter int HANDLE_COUNT = rhba_pkg::HANDLE_COUNT_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // in_tdata: handle [7:0], length [24:8], zero fill
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [rhba_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: command [2:0]
  input  wire [rhba_pkg::CODE_W-1:0]        in_tuser,
  // out_tdata: result_handle [7:0], region_offset [24:8],
  // region_length [41:25], released [42], zero fill
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [rhba_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: status [2:0]
  output logic [rhba_pkg::CODE_W-1:0]       out_tuser,
  // pool_size register write
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [rhba_pkg::LEN_W-1:0]         cfg_data
);
  import rhba_pkg::*;

  // table rows beyond what the 8-bit handle field can reach are never read
  localparam int TBL_DEPTH = (HANDLE_COUNT < TBL_MAX) ? HANDLE_COUNT : TBL_MAX;
  localparam int NH_W      = $clog2(HANDLE_COUNT + 1);

  state_t state_r, state_nxt;

  // command held for the execute step
  logic [CODE_W-1:0]   cmd_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [LEN_W-1:0]    len_r;

  // allocator state
  logic [LEN_W-1:0]    bump_r, bump_nxt;
  logic [NH_W-1:0]     next_handle_r, next_handle_nxt;
  logic [LEN_W-1:0]    limit_r;

  // output register
  logic                out_valid_r;
  logic [CODE_W-1:0]   out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [LEN_W-1:0]    out_off_r;
  logic [LEN_W-1:0]    out_len_r;
  logic                out_rel_r;

  logic [CODE_W-1:0]   res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [LEN_W-1:0]    res_off;
  logic [LEN_W-1:0]    res_len;
  logic                res_rel;

  logic                in_acc;
  logic                out_free;
  logic                exec_done;
  logic                hit;
  logic                handle_ok;
  logic                have_handle;
  logic                create_ok;

  alu_req_t            alu_req;
  logic [ALU_W-1:0]    alu_res;
  logic                alu_zero;
  logic                alu_le;

  tbl_wr_t             tbl_wr;
  entry_t              ent;
  logic                ent_live;

  rhba_table #(
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_en   (in_acc),
    .rd_addr (in_tdata[HANDLE_W-1:0]),
    .rd_data (ent),
    .rd_live (ent_live)
  );

  rhba_alu u_alu (
    .req  (alu_req),
    .res  (alu_res),
    .zero (alu_zero),
    .le   (alu_le)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_EXEC;
      S_EXEC: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    exec_done = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_EXEC: exec_done = out_free;
      default: in_tready = 1'b0;
    endcase
  end

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_tuser;
      handle_r <= in_tdata[HANDLE_W-1:0];
      len_r    <= in_tdata[HANDLE_W +: LEN_W];
    end
  end

  // --------------------------------------------------------- shared operands
  // create: bump + length against limit; checks: length difference;
  // add/drop: count plus or minus one
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_req.c  = {1'b0, limit_r};
    case (cmd_r)
      CMD_CREATE: begin
        alu_req.a = {1'b0, bump_r};
        alu_req.b = {1'b0, len_r};
      end
      CMD_WR_CHECK, CMD_RD_CHECK: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, len_r};
        alu_req.b  = {1'b0, ent.length};
      end
      CMD_ADD_REF: begin
        alu_req.a = ALU_W'(ent.refs);
        alu_req.b = ALU_W'(1);
      end
      CMD_DROP_REF: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(ent.refs);
        alu_req.b  = ALU_W'(1);
      end
      default: alu_req.op = ALU_ADD;
    endcase
  end

  // ----------------------------------------------------------- resolve item
  assign handle_ok   = (int'(handle_r) < HANDLE_COUNT);
  assign hit         = handle_ok && ent_live;
  assign have_handle = (next_handle_r < NH_W'(HANDLE_COUNT));
  assign create_ok   = alu_le && have_handle;

  always_comb begin
    res_status  = STS_UNKNOWN;
    res_handle  = handle_r;
    res_off     = '0;
    res_len     = '0;
    res_rel     = 1'b0;
    tbl_wr.en   = 1'b0;
    tbl_wr.live = 1'b1;
    tbl_wr.addr = handle_r;
    tbl_wr.data = ent;
    case (cmd_r)
      CMD_CREATE: begin
        res_handle = '0;
        if (!alu_le) begin
          res_status = STS_POOL_FULL;
        end else if (!have_handle) begin
          res_status = STS_NO_HANDLE;
        end else begin
          res_status       = STS_OK;
          res_handle       = HANDLE_W'(next_handle_r);
          res_off          = bump_r;
          res_len          = len_r;
          tbl_wr.en        = (int'(next_handle_r) < TBL_DEPTH);
          tbl_wr.addr      = HANDLE_W'(next_handle_r);
          tbl_wr.data.refs = REFS_W'(1);
          tbl_wr.data.length = len_r;
          tbl_wr.data.offset = bump_r;
        end
      end
      CMD_WR_CHECK, CMD_RD_CHECK: begin
        if (hit) begin
          res_status = alu_zero ? STS_OK : STS_MISMATCH;
          res_off    = ent.offset;
          res_len    = ent.length;
        end
      end
      CMD_ADD_REF: begin
        if (hit) begin
          res_status       = STS_OK;
          res_off          = ent.offset;
          res_len          = ent.length;
          tbl_wr.en        = 1'b1;
          tbl_wr.data.refs = (ent.refs == REFS_MAX) ? ent.refs : alu_res[REFS_W-1:0];
        end
      end
      CMD_DROP_REF: begin
        if (hit) begin
          res_status = STS_OK;
          res_off    = ent.offset;
          res_len    = ent.length;
          tbl_wr.en  = 1'b1;
          // count of one or less: last reference goes away
          if (ent.refs[REFS_W-1:1] == '0) begin
            res_rel          = 1'b1;
            tbl_wr.live      = 1'b0;
            tbl_wr.data.refs = '0;
          end else begin
            tbl_wr.data.refs = alu_res[REFS_W-1:0];
          end
        end
      end
      default: res_status = STS_UNKNOWN;
    endcase
    // table is only written on the cycle the result is handed over
    tbl_wr.en = tbl_wr.en && exec_done;
  end

  // ------------------------------------------------------- allocator state
  always_comb begin
    bump_nxt        = bump_r;
    next_handle_nxt = next_handle_r;
    if (exec_done && (cmd_r == CMD_CREATE) && create_ok) begin
      bump_nxt        = alu_res[LEN_W-1:0];
      next_handle_nxt = next_handle_r + NH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_r        <= '0;
      next_handle_r <= NH_W'(1);
      limit_r       <= (POOL_SIZE_RST < POOL_LIM) ? POOL_SIZE_RST : POOL_LIM;
    end else begin
      bump_r        <= bump_nxt;
      next_handle_r <= next_handle_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= (cfg_data < POOL_LIM) ? cfg_data : POOL_LIM;
      end
    end
  end

  assign cfg_ready = 1'b1;

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_status_r <= res_status;
      out_handle_r <= res_handle;
      out_off_r    <= res_off;
      out_len_r    <= res_len;
      out_rel_r    <= res_rel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'd0, out_rel_r, out_len_r, out_off_r, out_handle_r};

`ifndef NO_ASSERTIONS
  // an accepted item always occupies the sequencer for its execute step
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // the bump offset never passes the physical pool
  a_bump_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= POOL_LIM)
    else $error("bump offset beyond pool");

  // handle counter stops at HANDLE_COUNT
  a_handle_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_handle_r <= NH_W'(HANDLE_COUNT))
    else $error("handle counter overran");

  // a freed entry is only reported on a successful drop
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    exec_done && res_rel |-> (cmd_r == CMD_DROP_REF) && (res_status == STS_OK))
    else $error("release flagged on wrong command");
`endif

endmodule

`default_nettype wire
